[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, used by the top level to check its own logic.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, skipped while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Concurrent check on the rising clock edge that holds during reset as well.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// Types and codes shared by the MIDI event remapper controller and datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Default number of tracks that carry events.
  localparam int TRACKS_DEFAULT = 16;

  // Upper nibble of the MIDI status byte.
  localparam logic [3:0] CMD_NOTE_OFF    = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON     = 4'h9;
  localparam logic [3:0] CMD_PROGRAM     = 4'hC;
  localparam logic [3:0] CMD_PITCH_BEND  = 4'hE;

  // Result actions.
  localparam logic [1:0] ACT_NOTE_OFF    = 2'd0;
  localparam logic [1:0] ACT_NOTE_ON     = 2'd1;
  localparam logic [1:0] ACT_PROGRAM     = 2'd2;
  localparam logic [1:0] ACT_PITCH_BEND  = 2'd3;

  // Table select codes of a table write.
  localparam logic [2:0] TBL_FM_NOTE     = 3'd0;
  localparam logic [2:0] TBL_FM_VEL      = 3'd1;
  localparam logic [2:0] TBL_FM_MATCH    = 3'd2;
  localparam logic [2:0] TBL_MT_MATCH    = 3'd3;
  localparam logic [2:0] TBL_MT_VEL      = 3'd4;
  localparam logic [2:0] TBL_MT_NOTE     = 3'd5;
  localparam logic [2:0] TBL_HW_CHANNEL  = 3'd6;
  localparam logic [2:0] TBL_SUBST_PROG  = 3'd7;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNTH_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FM_LOOKUP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DRUM_SUBST   = 2'd2;

  // Hardware channel that carries drums.
  localparam logic [3:0] DRUM_CHANNEL = 4'd9;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } mer_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted request
    logic calc;      // table reads, sums and program compares
    logic commit;    // finish the request
    logic load_out;  // load the output register with the result
  } mer_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
  } mer_status_t;

endpackage

[rtl/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for one request at a time and the output valid flag.
// ----------------------------------------------------------------------------
module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mer_pkg::mer_status_t status,
  output mer_pkg::mer_cmd_t    cmd
);

  mer_pkg::mer_state_t state;
  mer_pkg::mer_state_t state_next;
  logic                out_valid_next;
  logic                out_free;
  logic                finish;

  // State and output flag registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mer_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    out_free     = !out_valid || out_ready;
    finish       = 1'b0;
    in_ready     = 1'b0;
    cmd          = '0;
    state_next   = state;
    case (state)
      mer_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = mer_pkg::ST_CALC;
        end
      end
      mer_pkg::ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = mer_pkg::ST_DONE;
      end
      mer_pkg::ST_DONE: begin
        // A result waits here until the output register is free.
        finish       = out_free || !status.has_result;
        in_ready     = finish;
        cmd.commit   = finish;
        cmd.load_out = finish && status.has_result;
        if (finish) begin
          state_next = in_valid ? mer_pkg::ST_CALC : mer_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mer_pkg::ST_IDLE;
      end
    endcase
    cmd.load = in_valid && in_ready;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

[rtl/mer_datapath.sv]
// ----------------------------------------------------------------------------
// mer_datapath
// Remap tables, offset arithmetic, program search and the output register.
// ----------------------------------------------------------------------------
module mer_datapath #(
  parameter int TRACKS = mer_pkg::TRACKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mer_pkg::mer_cmd_t               cmd,
  output mer_pkg::mer_status_t            status,
  input  logic                            cfg_we,
  input  logic [mer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_data,
  input  logic                            kind,
  input  logic [3:0]                      track,
  input  logic [7:0]                      command,
  input  logic [6:0]                      param_one,
  input  logic [6:0]                      param_two,
  input  logic [2:0]                      table_select,
  input  logic [3:0]                      table_index,
  input  logic signed [15:0]              table_value,
  output logic [1:0]                      action,
  output logic [3:0]                      channel,
  output logic [6:0]                      note_out,
  output logic [6:0]                      velocity_out,
  output logic [6:0]                      program_out,
  output logic [6:0]                      bend_low,
  output logic [6:0]                      bend_high,
  output logic [3:0]                      instrument_out
);

  localparam int TRK_IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  // Saturate an 18-bit two's complement value to 0..127.
  function automatic logic [6:0] clamp7(input logic [17:0] v);
    logic [6:0] r;
    if (v[17]) begin
      r = 7'd0;
    end else if (|v[16:7]) begin
      r = 7'd127;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  // Position of the lowest set bit of an 8-bit vector.
  function automatic logic [2:0] first_set8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Configuration registers.
  logic synth_mode;
  logic fm_instrument_lookup;
  logic drum_note_substitute;

  // Remap tables.
  logic [3:0]  track_instrument    [TRACKS];
  logic [15:0] fm_note_offsets     [16];
  logic [15:0] fm_velocity_offsets [16];
  logic [15:0] fm_program_matches  [16];
  logic [15:0] mt_program_matches  [16];
  logic [15:0] mt_velocity_offsets [16];
  logic [15:0] mt_note_offsets     [16];
  logic [3:0]  hw_channel_map      [16];
  logic [6:0]  substitute_programs [16];

  // Captured request.
  logic        item_kind;
  logic [3:0]  item_track;
  logic [3:0]  item_cmd;
  logic [6:0]  item_param_one;
  logic [6:0]  item_param_two;
  logic [2:0]  item_table_select;
  logic [3:0]  item_table_index;
  logic [15:0] item_table_value;

  // Calculation stage registers.
  logic [17:0] note_sum;
  logic [17:0] vel_sum;
  logic [15:0] match_vec;
  logic [3:0]  inst;
  logic [3:0]  hwc;

  // Calculation stage logic.
  logic [TRK_IDX_W-1:0] trk_idx;
  logic [3:0]  inst_rd;
  logic [3:0]  hwc_rd;
  logic [3:0]  fm_k;
  logic [15:0] note_off;
  logic [15:0] vel_off;
  logic        drum_sub;
  logic [17:0] note_sum_next;
  logic [17:0] vel_sum_next;
  logic [15:0] match_next;

  // Completion logic.
  logic        in_range;
  logic        is_note;
  logic        note_on;
  logic        vel_gate;
  logic [6:0]  vel_c;
  logic [12:0] vel_prod;
  logic        match_found;
  logic [3:0]  match_idx;
  logic        res_valid;
  logic [1:0]  res_action;
  logic [3:0]  res_channel;
  logic [6:0]  res_note;
  logic [6:0]  res_vel;
  logic [6:0]  res_program;
  logic [6:0]  res_bend_low;
  logic [6:0]  res_bend_high;
  logic [3:0]  res_instrument;

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      synth_mode           <= 1'b0;
      fm_instrument_lookup <= 1'b0;
      drum_note_substitute <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mer_pkg::REG_SYNTH_MODE: synth_mode           <= cfg_data;
        mer_pkg::REG_FM_LOOKUP:  fm_instrument_lookup <= cfg_data;
        mer_pkg::REG_DRUM_SUBST: drum_note_substitute <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted request.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind         <= kind;
      item_track        <= track;
      item_cmd          <= command[7:4];
      item_param_one    <= param_one;
      item_param_two    <= param_two;
      item_table_select <= table_select;
      item_table_index  <= table_index;
      item_table_value  <= table_value;
    end
  end

  // Table reads, offset sums and the sixteen program compares.
  always_comb begin
    trk_idx  = item_track[TRK_IDX_W-1:0];
    inst_rd  = track_instrument[trk_idx];
    hwc_rd   = hw_channel_map[item_track];
    fm_k     = fm_instrument_lookup ? inst_rd : item_track;
    note_off = synth_mode ? mt_note_offsets[inst_rd] : fm_note_offsets[fm_k];
    vel_off  = synth_mode ? mt_velocity_offsets[inst_rd] : fm_velocity_offsets[fm_k];
    drum_sub = synth_mode && drum_note_substitute && (hwc_rd == mer_pkg::DRUM_CHANNEL);
    if (drum_sub) begin
      note_sum_next = {{2{note_off[15]}}, note_off};
    end else begin
      note_sum_next = {11'd0, item_param_one} + {{2{note_off[15]}}, note_off};
    end
    vel_sum_next = {11'd0, item_param_two} + {{2{vel_off[15]}}, vel_off};
    for (int k = 0; k < 16; k++) begin
      match_next[k] = (synth_mode ? mt_program_matches[k] : fm_program_matches[k])
                      == {9'd0, item_param_one};
    end
  end

  // Calculation stage registers and table writes.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      note_sum  <= note_sum_next;
      vel_sum   <= vel_sum_next;
      match_vec <= match_next;
      inst      <= inst_rd;
      hwc       <= hwc_rd;
      if (item_kind) begin
        case (item_table_select)
          mer_pkg::TBL_FM_NOTE:    fm_note_offsets[item_table_index]     <= item_table_value;
          mer_pkg::TBL_FM_VEL:     fm_velocity_offsets[item_table_index] <= item_table_value;
          mer_pkg::TBL_FM_MATCH:   fm_program_matches[item_table_index]  <= item_table_value;
          mer_pkg::TBL_MT_MATCH:   mt_program_matches[item_table_index]  <= item_table_value;
          mer_pkg::TBL_MT_VEL:     mt_velocity_offsets[item_table_index] <= item_table_value;
          mer_pkg::TBL_MT_NOTE:    mt_note_offsets[item_table_index]     <= item_table_value;
          mer_pkg::TBL_HW_CHANNEL: hw_channel_map[item_table_index] <= item_table_value[3:0];
          default: substitute_programs[item_table_index] <= item_table_value[6:0];
        endcase
      end
    end
  end

  // Result formation from the stage registers.
  always_comb begin
    in_range = ({1'b0, item_track} < 5'(TRACKS));
    is_note  = (item_cmd == mer_pkg::CMD_NOTE_OFF) || (item_cmd == mer_pkg::CMD_NOTE_ON);
    note_on  = (item_cmd == mer_pkg::CMD_NOTE_ON) && (item_param_two != 7'd0);
    vel_gate = note_on || (item_cmd == mer_pkg::CMD_NOTE_OFF);
    vel_c    = vel_gate ? clamp7(vel_sum) : 7'd0;
    // Scale by 63/64: v * 63 is v * 64 - v.
    vel_prod = {vel_c, 6'd0} - {6'd0, vel_c};

    // Lowest matching program entry, split into two halves of eight.
    match_found = |match_vec;
    if (|match_vec[7:0]) begin
      match_idx = {1'b0, first_set8(match_vec[7:0])};
    end else begin
      match_idx = {1'b1, first_set8(match_vec[15:8])};
    end

    res_valid      = 1'b0;
    res_action     = mer_pkg::ACT_NOTE_OFF;
    res_channel    = synth_mode ? hwc : item_track;
    res_note       = 7'd0;
    res_vel        = 7'd0;
    res_program    = 7'd0;
    res_bend_low   = 7'd0;
    res_bend_high  = 7'd0;
    res_instrument = 4'd0;
    if (!item_kind && in_range) begin
      if (is_note) begin
        res_valid  = 1'b1;
        res_action = note_on ? mer_pkg::ACT_NOTE_ON : mer_pkg::ACT_NOTE_OFF;
        res_note   = clamp7(note_sum);
        if (synth_mode) begin
          res_vel = vel_prod[12:6];
        end else begin
          res_vel        = vel_c;
          res_instrument = inst;
        end
      end else if (item_cmd == mer_pkg::CMD_PROGRAM) begin
        if (synth_mode && match_found) begin
          res_valid   = 1'b1;
          res_action  = mer_pkg::ACT_PROGRAM;
          res_program = substitute_programs[match_idx];
        end
      end else if (item_cmd == mer_pkg::CMD_PITCH_BEND) begin
        res_valid     = 1'b1;
        res_action    = mer_pkg::ACT_PITCH_BEND;
        res_bend_low  = item_param_one;
        res_bend_high = item_param_two;
      end
    end
    status.has_result = res_valid;
  end

  // Track instruments; an FM program change retargets the track.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKS; i++) begin
        track_instrument[i] <= 4'(i);
      end
    end else if (cmd.commit && !item_kind && in_range && !synth_mode
                 && fm_instrument_lookup && match_found
                 && (item_cmd == mer_pkg::CMD_PROGRAM)) begin
      track_instrument[trk_idx] <= match_idx;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      action         <= res_action;
      channel        <= res_channel;
      note_out       <= res_note;
      velocity_out   <= res_vel;
      program_out    <= res_program;
      bend_low       <= res_bend_low;
      bend_high      <= res_bend_high;
      instrument_out <= res_instrument;
    end
  end

endmodule

[rtl/midi_event_remapper_top.sv]
// Steps: capture, then the table read and compare stage, then completion, which loads any
// result into the output register. A new request is taken in the completion state
// while the output register is free; a result that finds it still full holds the input.
// Program search compares all sixteen entries in the calculation cycle.
// Reset (rst, synchronous, active high): config cleared, track i plays instrument i,
// remap tables stay undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
// midi_event_remapper_top
// Remaps MIDI channel events of a track into synth commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_event_remapper_top #(
  parameter int TRACKS = mer_pkg::TRACKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [3:0]                      track,
  input  logic [7:0]                      command,
  input  logic [6:0]                      param_one,
  input  logic [6:0]                      param_two,
  input  logic [2:0]                      table_select,
  input  logic [3:0]                      table_index,
  input  logic signed [15:0]              table_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      action,
  output logic [3:0]                      channel,
  output logic [6:0]                      note_out,
  output logic [6:0]                      velocity_out,
  output logic [6:0]                      program_out,
  output logic [6:0]                      bend_low,
  output logic [6:0]                      bend_high,
  output logic [3:0]                      instrument_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_data
);

  mer_pkg::mer_cmd_t    cmd;
  mer_pkg::mer_status_t status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Sequencer.
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Tables and arithmetic.
  mer_datapath #(
    .TRACKS (TRACKS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .kind           (kind),
    .track          (track),
    .command        (command),
    .param_one      (param_one),
    .param_two      (param_two),
    .table_select   (table_select),
    .table_index    (table_index),
    .table_value    (table_value),
    .action         (action),
    .channel        (channel),
    .note_out       (note_out),
    .velocity_out   (velocity_out),
    .program_out    (program_out),
    .bend_low       (bend_low),
    .bend_high      (bend_high),
    .instrument_out (instrument_out)
  );

  // An accepted request always goes through the calculation cycle next.
  `ASSERT_CLK_RST(a_accept_then_calc, clk, rst, (in_valid && in_ready) |=> (cmd.calc && !in_ready))
  // A result never overwrites one that has not been taken.
  `ASSERT_CLK_RST(a_no_overwrite, clk, rst, cmd.load_out |-> (!out_valid || out_ready))
  // Calculation and completion never happen in the same cycle.
  `ASSERT_CLK(a_calc_commit_apart, clk, $onehot0({cmd.calc, cmd.commit}))

endmodule

[dv/midi_event_remapper_top_tb.sv]
// ----------------------------------------------------------------------------
// midi_event_remapper_top_tb
// Self-checking bench for the MIDI event remapper. All remap tables are
// loaded first, then a table of directed requests runs, followed by random
// phases under several register settings. Every accepted request goes
// through a local remap model, and each synth command that comes out of the
// block is compared field by field with the oldest predicted command.
// ----------------------------------------------------------------------------
module midi_event_remapper_top_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_ITEMS   = 63;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    BY_MODEL,
    EXPECT_NONE,
    EXPECT_CMD
  } check_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_CONFIG
  } row_op_t;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [6:0] prog;
    logic [6:0] bend_lo;
    logic [6:0] bend_hi;
    logic [3:0] instrument;
  } synth_cmd_t;

  typedef struct packed {
    row_op_t     op;
    check_t      chk;
    logic [2:0]  cfg_bits;  // {drum_note_substitute, fm_instrument_lookup, synth_mode}
    logic        kind;
    logic [3:0]  track;
    logic [7:0]  command;
    logic [6:0]  p1;
    logic [6:0]  p2;
    logic [2:0]  sel;
    logic [3:0]  idx;
    logic [15:0] value;
    synth_cmd_t  want;
  } midi_req_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [3:0]  track;
  logic [7:0]  command;
  logic [6:0]  param_one;
  logic [6:0]  param_two;
  logic [2:0]  table_select;
  logic [3:0]  table_index;
  logic signed [15:0] table_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  action;
  logic [3:0]  channel;
  logic [6:0]  note_out;
  logic [6:0]  velocity_out;
  logic [6:0]  program_out;
  logic [6:0]  bend_low;
  logic [6:0]  bend_high;
  logic [3:0]  instrument_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [mer_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic        cfg_data;

  // Remap model state.
  logic               mode_mt;
  logic               fm_lookup;
  logic               drum_subst;
  logic [3:0]         trk_instr   [16];
  logic signed [15:0] fm_note_ofs [16];
  logic signed [15:0] fm_vel_ofs  [16];
  logic signed [15:0] fm_match    [16];
  logic signed [15:0] mt_match    [16];
  logic signed [15:0] mt_vel_ofs  [16];
  logic signed [15:0] mt_note_ofs [16];
  logic [3:0]         hw_chan     [16];
  logic [6:0]         subst_prog  [16];

  synth_cmd_t pending_cmds[$];
  int         fail_count;
  int         cycle_count;
  int         hold_left;
  bit         hold_done;
  logic       idle_on;
  logic       hold_request;

  midi_event_remapper_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .track          (track),
    .command        (command),
    .param_one      (param_one),
    .param_two      (param_two),
    .table_select   (table_select),
    .table_index    (table_index),
    .table_value    (table_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .channel        (channel),
    .note_out       (note_out),
    .velocity_out   (velocity_out),
    .program_out    (program_out),
    .bend_low       (bend_low),
    .bend_high      (bend_high),
    .instrument_out (instrument_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [6:0] sat7(input int v);
    if (v < 0) return 7'd0;
    if (v > 127) return 7'd127;
    return v[6:0];
  endfunction

  // Updates the model with one request and returns the command it causes.
  task automatic remap_request(input midi_req_t r, output logic produced,
                               output synth_cmd_t res);
    logic [3:0] inst;
    logic [3:0] hwc;
    logic [3:0] k;
    logic [3:0] nib;
    logic       on;
    logic       found;
    int         note;
    int         vel;
    int         scaled;
    int         i;
    res = '0;
    produced = 1'b0;
    if (r.kind) begin
      case (r.sel)
        mer_pkg::TBL_FM_NOTE:    fm_note_ofs[r.idx] = r.value;
        mer_pkg::TBL_FM_VEL:     fm_vel_ofs[r.idx] = r.value;
        mer_pkg::TBL_FM_MATCH:   fm_match[r.idx] = r.value;
        mer_pkg::TBL_MT_MATCH:   mt_match[r.idx] = r.value;
        mer_pkg::TBL_MT_VEL:     mt_vel_ofs[r.idx] = r.value;
        mer_pkg::TBL_MT_NOTE:    mt_note_ofs[r.idx] = r.value;
        mer_pkg::TBL_HW_CHANNEL: hw_chan[r.idx] = r.value[3:0];
        default:                 subst_prog[r.idx] = r.value[6:0];
      endcase
      return;
    end
    inst = trk_instr[r.track];
    hwc = hw_chan[r.track];
    nib = r.command[7:4];
    found = 1'b0;
    if (nib == mer_pkg::CMD_NOTE_OFF || nib == mer_pkg::CMD_NOTE_ON) begin
      on = (nib == mer_pkg::CMD_NOTE_ON) && (r.p2 != 7'd0);
      if (mode_mt) begin
        note = int'(r.p1) + int'(mt_note_ofs[inst]);
        vel = (on || nib == mer_pkg::CMD_NOTE_OFF) ?
              int'(sat7(int'(r.p2) + int'(mt_vel_ofs[inst]))) : 0;
        // Drums on the drum channel play the instrument's fixed note.
        if (drum_subst && hwc == mer_pkg::DRUM_CHANNEL) note = int'(mt_note_ofs[inst]);
        scaled = (vel * 63) >> 6;
        res.channel = hwc;
        res.velocity = scaled[6:0];
      end else begin
        k = fm_lookup ? inst : r.track;
        note = int'(r.p1) + int'(fm_note_ofs[k]);
        vel = (on || nib == mer_pkg::CMD_NOTE_OFF) ?
              int'(sat7(int'(r.p2) + int'(fm_vel_ofs[k]))) : 0;
        res.channel = r.track;
        res.velocity = vel[6:0];
        res.instrument = inst;
      end
      res.action = on ? mer_pkg::ACT_NOTE_ON : mer_pkg::ACT_NOTE_OFF;
      res.note = sat7(note);
      produced = 1'b1;
    end else if (nib == mer_pkg::CMD_PROGRAM) begin
      // First matching entry wins in both modes.
      for (i = 0; i < 16; i++) begin
        if (!found && mode_mt && mt_match[i] == {9'd0, r.p1}) begin
          found = 1'b1;
          res.action = mer_pkg::ACT_PROGRAM;
          res.channel = hwc;
          res.prog = subst_prog[i];
          produced = 1'b1;
        end else if (!found && !mode_mt && fm_lookup && fm_match[i] == {9'd0, r.p1}) begin
          found = 1'b1;
          trk_instr[r.track] = i[3:0];
        end
      end
    end else if (nib == mer_pkg::CMD_PITCH_BEND) begin
      res.action = mer_pkg::ACT_PITCH_BEND;
      res.channel = mode_mt ? hwc : r.track;
      res.bend_lo = r.p1;
      res.bend_hi = r.p2;
      produced = 1'b1;
    end
  endtask

  function automatic midi_req_t midi_row(input logic [3:0] trk, input logic [7:0] cmd,
                                         input logic [6:0] a, input logic [6:0] b,
                                         input check_t chk, input synth_cmd_t want);
    midi_req_t r;
    r = '0;
    r.op = ROW_REQUEST;
    r.chk = chk;
    r.track = trk;
    r.command = cmd;
    r.p1 = a;
    r.p2 = b;
    r.want = want;
    return r;
  endfunction

  function automatic midi_req_t table_row(input logic [2:0] sel, input logic [3:0] idx,
                                          input logic [15:0] value);
    midi_req_t r;
    r = '0;
    r.op = ROW_REQUEST;
    r.chk = EXPECT_NONE;
    r.kind = 1'b1;
    r.sel = sel;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic midi_req_t config_row(input logic [2:0] bits);
    midi_req_t r;
    r = '0;
    r.op = ROW_CONFIG;
    r.cfg_bits = bits;
    return r;
  endfunction

  function automatic synth_cmd_t note_cmd(input logic [1:0] act, input logic [3:0] ch,
                                          input logic [6:0] nt, input logic [6:0] vel,
                                          input logic [3:0] inst);
    synth_cmd_t c;
    c = '0;
    c.action = act;
    c.channel = ch;
    c.note = nt;
    c.velocity = vel;
    c.instrument = inst;
    return c;
  endfunction

  function automatic synth_cmd_t bend_cmd(input logic [3:0] ch, input logic [6:0] lo,
                                          input logic [6:0] hi);
    synth_cmd_t c;
    c = '0;
    c.action = mer_pkg::ACT_PITCH_BEND;
    c.channel = ch;
    c.bend_lo = lo;
    c.bend_hi = hi;
    return c;
  endfunction

  // Random request, mostly well-formed events with table reloads mixed in.
  function automatic midi_req_t random_request();
    midi_req_t r;
    int        pick;
    int        tmp;
    int        j;
    r = '0;
    r.op = ROW_REQUEST;
    r.chk = BY_MODEL;
    r.track = 4'($urandom_range(15));
    r.command = 8'($urandom_range(255));
    r.p1 = 7'($urandom_range(127));
    r.p2 = 7'($urandom_range(127));
    r.sel = 3'($urandom_range(7));
    r.idx = 4'($urandom_range(15));
    tmp = $urandom_range(65535);
    r.value = tmp[15:0];
    pick = $urandom_range(99);
    if (pick < 22) begin
      r.kind = 1'b1;
      pick = $urandom_range(99);
      case (r.sel)
        mer_pkg::TBL_FM_MATCH, mer_pkg::TBL_MT_MATCH: begin
          if (pick < 70) r.value = 16'($urandom_range(127));
        end
        mer_pkg::TBL_HW_CHANNEL: begin
          if (pick < 40) r.value = {12'd0, mer_pkg::DRUM_CHANNEL};
        end
        mer_pkg::TBL_SUBST_PROG: ;
        default: begin
          if (pick < 50) tmp = int'($urandom_range(48)) - 24;
          else if (pick < 80) tmp = int'($urandom_range(280)) - 140;
          r.value = tmp[15:0];
        end
      endcase
    end else begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        r.command[7:4] = mer_pkg::CMD_NOTE_ON;
        if ($urandom_range(99) < 15) r.p2 = 7'd0;
      end else if (pick < 50) begin
        r.command[7:4] = mer_pkg::CMD_NOTE_OFF;
      end else if (pick < 70) begin
        r.command[7:4] = mer_pkg::CMD_PROGRAM;
        // Aim most program changes at a loaded match entry.
        j = $urandom_range(15);
        if ($urandom_range(99) < 70) r.p1 = mode_mt ? mt_match[j][6:0] : fm_match[j][6:0];
      end else if (pick < 85) begin
        r.command[7:4] = mer_pkg::CMD_PITCH_BEND;
      end
    end
    return r;
  endfunction

  // Offers one request, with random gaps, and predicts it once accepted.
  task automatic send_request(input midi_req_t r);
    logic       produced;
    synth_cmd_t res;
    while (idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= r.kind;
    track        <= r.track;
    command      <= r.command;
    param_one    <= r.p1;
    param_two    <= r.p2;
    table_select <= r.sel;
    table_index  <= r.idx;
    table_value  <= r.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    remap_request(r, produced, res);
    if (r.chk == EXPECT_CMD) begin
      produced = 1'b1;
      res = r.want;
    end else if (r.chk == EXPECT_NONE) begin
      produced = 1'b0;
    end
    if (produced) pending_cmds.push_back(res);
  endtask

  // Waits until every predicted command has come out and the block is quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no gap.
  task automatic write_register(input logic [mer_pkg::CFG_INDEX_W-1:0] index,
                                input logic data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Bits are {drum_note_substitute, fm_instrument_lookup, synth_mode}.
  task automatic program_registers(input logic [2:0] bits);
    drain_block();
    write_register(mer_pkg::REG_SYNTH_MODE, bits[0]);
    write_register(mer_pkg::REG_FM_LOOKUP, bits[1]);
    write_register(mer_pkg::REG_DRUM_SUBST, bits[2]);
    cfg_valid <= 1'b0;
    mode_mt = bits[0];
    fm_lookup = bits[1];
    drum_subst = bits[2];
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: random back-pressure, plus one long hold when asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_on || ($urandom_range(99) >= 29);
    end
  end

  // Compare each accepted command with the oldest prediction.
  always @(posedge clk) begin : result_check
    synth_cmd_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("synth command with nothing predicted: action %0d channel %0d",
               action, channel);
        fail_count++;
      end else begin
        want = pending_cmds.pop_front();
        check_field("action", int'(want.action), int'(action));
        check_field("channel", int'(want.channel), int'(channel));
        check_field("note_out", int'(want.note), int'(note_out));
        check_field("velocity_out", int'(want.velocity), int'(velocity_out));
        check_field("program_out", int'(want.prog), int'(program_out));
        check_field("bend_low", int'(want.bend_lo), int'(bend_low));
        check_field("bend_high", int'(want.bend_hi), int'(bend_high));
        check_field("instrument_out", int'(want.instrument), int'(instrument_out));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    midi_req_t plan[$];
    midi_req_t row;
    logic [2:0] phase_cfg [7];
    int s;
    int e;
    int ph;

    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    track = '0;
    command = '0;
    param_one = '0;
    param_two = '0;
    table_select = '0;
    table_index = '0;
    table_value = '0;
    cfg_valid = 1'b0;
    cfg_index = mer_pkg::REG_SYNTH_MODE;
    cfg_data = 1'b0;
    hold_request = 1'b0;
    idle_on = 1'b1;
    mode_mt = 1'b0;
    fm_lookup = 1'b0;
    drum_subst = 1'b0;
    for (s = 0; s < 16; s++) trk_instr[s] = s[3:0];

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Load every table entry: offsets zero, no program matches,
    // hardware channel equal to the track.
    for (s = 0; s < 8; s++) begin
      for (e = 0; e < 16; e++) begin
        row = table_row(s[2:0], e[3:0], 16'd0);
        if (s[2:0] == mer_pkg::TBL_FM_MATCH || s[2:0] == mer_pkg::TBL_MT_MATCH) begin
          row.value = 16'hFFFF;
        end
        if (s[2:0] == mer_pkg::TBL_HW_CHANNEL) row.value = e[15:0];
        send_request(row);
      end
    end

    // Directed requests, FM path with registers at reset values first.
    plan.push_back(midi_row(4'd0, {mer_pkg::CMD_NOTE_ON, 4'h0}, 7'd60, 7'd100, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_ON, 4'd0, 7'd60, 7'd100, 4'd0)));
    plan.push_back(midi_row(4'd15, {mer_pkg::CMD_NOTE_ON, 4'hF}, 7'd127, 7'd127, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_ON, 4'd15, 7'd127, 7'd127, 4'd15)));
    // Note-on with zero velocity turns into a note-off.
    plan.push_back(midi_row(4'd3, {mer_pkg::CMD_NOTE_ON, 4'h3}, 7'd0, 7'd0, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_OFF, 4'd3, 7'd0, 7'd0, 4'd3)));
    plan.push_back(midi_row(4'd5, {mer_pkg::CMD_NOTE_OFF, 4'h5}, 7'd64, 7'd64, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_OFF, 4'd5, 7'd64, 7'd64, 4'd5)));
    plan.push_back(midi_row(4'd7, {mer_pkg::CMD_PITCH_BEND, 4'h7}, 7'd127, 7'd0, EXPECT_CMD,
                            bend_cmd(4'd7, 7'd127, 7'd0)));
    plan.push_back(midi_row(4'd2, {mer_pkg::CMD_PITCH_BEND, 4'h2}, 7'd0, 7'd127, EXPECT_CMD,
                            bend_cmd(4'd2, 7'd0, 7'd127)));
    // Channel pressure and system status bytes are dropped.
    plan.push_back(midi_row(4'd1, 8'hD1, 7'd10, 7'd10, EXPECT_NONE, '0));
    plan.push_back(midi_row(4'd14, 8'hFF, 7'd127, 7'd127, EXPECT_NONE, '0));
    // Program change with lookup off only could retarget, and does not.
    plan.push_back(midi_row(4'd1, {mer_pkg::CMD_PROGRAM, 4'h1}, 7'd42, 7'd0, EXPECT_NONE,
                            '0));
    // Note saturation at both ends and velocity clamping.
    plan.push_back(table_row(mer_pkg::TBL_FM_NOTE, 4'd4, 16'h7FFF));
    plan.push_back(midi_row(4'd4, {mer_pkg::CMD_NOTE_ON, 4'h4}, 7'd0, 7'd1, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_ON, 4'd4, 7'd127, 7'd1, 4'd4)));
    plan.push_back(table_row(mer_pkg::TBL_FM_NOTE, 4'd4, 16'h8000));
    plan.push_back(table_row(mer_pkg::TBL_FM_VEL, 4'd4, 16'd200));
    plan.push_back(midi_row(4'd4, {mer_pkg::CMD_NOTE_ON, 4'h4}, 7'd127, 7'd1, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_ON, 4'd4, 7'd0, 7'd127, 4'd4)));
    plan.push_back(table_row(mer_pkg::TBL_FM_VEL, 4'd5, 16'h8000));
    plan.push_back(midi_row(4'd5, {mer_pkg::CMD_NOTE_OFF, 4'h5}, 7'd10, 7'd127, EXPECT_CMD,
                            note_cmd(mer_pkg::ACT_NOTE_OFF, 4'd5, 7'd10, 7'd0, 4'd5)));
    // FM program change retargets the track's instrument.
    plan.push_back(table_row(mer_pkg::TBL_FM_MATCH, 4'd6, 16'd42));
    plan.push_back(config_row(3'b010));
    plan.push_back(midi_row(4'd1, {mer_pkg::CMD_PROGRAM, 4'h1}, 7'd42, 7'd0, EXPECT_NONE,
                            '0));
    plan.push_back(midi_row(4'd1, {mer_pkg::CMD_NOTE_ON, 4'h1}, 7'd50, 7'd90, BY_MODEL, '0));
    // MT path with drum substitution on channel 9.
    plan.push_back(config_row(3'b101));
    plan.push_back(table_row(mer_pkg::TBL_HW_CHANNEL, 4'd2, 16'd9));
    plan.push_back(table_row(mer_pkg::TBL_MT_NOTE, 4'd2, 16'd35));
    plan.push_back(midi_row(4'd2, {mer_pkg::CMD_NOTE_ON, 4'h2}, 7'd60, 7'd127, BY_MODEL, '0));
    plan.push_back(table_row(mer_pkg::TBL_MT_MATCH, 4'd3, 16'd5));
    plan.push_back(table_row(mer_pkg::TBL_SUBST_PROG, 4'd3, 16'd127));
    plan.push_back(midi_row(4'd0, {mer_pkg::CMD_PROGRAM, 4'h0}, 7'd5, 7'd0, BY_MODEL, '0));
    plan.push_back(midi_row(4'd0, {mer_pkg::CMD_PROGRAM, 4'h0}, 7'd6, 7'd0, EXPECT_NONE,
                            '0));
    plan.push_back(midi_row(4'd2, {mer_pkg::CMD_PITCH_BEND, 4'h2}, 7'd1, 7'd2, BY_MODEL,
                            '0));
    plan.push_back(table_row(mer_pkg::TBL_MT_VEL, 4'd8, 16'h7FFF));
    plan.push_back(midi_row(4'd8, {mer_pkg::CMD_NOTE_OFF, 4'h8}, 7'd0, 7'd0, BY_MODEL, '0));
    plan.push_back(config_row(3'b000));

    foreach (plan[n]) begin
      if (plan[n].op == ROW_CONFIG) program_registers(plan[n].cfg_bits);
      else send_request(plan[n]);
    end

    // Random phases; the third runs without any idling, the fourth
    // starts with a long receiver hold so the block backs up.
    phase_cfg[0] = 3'b000;
    phase_cfg[1] = 3'b010;
    phase_cfg[2] = 3'b101;
    phase_cfg[3] = 3'b011;
    phase_cfg[4] = 3'b110;
    phase_cfg[5] = 3'b111;
    phase_cfg[6] = 3'($urandom_range(7));
    for (ph = 0; ph < 7; ph++) begin
      program_registers(phase_cfg[ph]);
      idle_on = (ph != 2);
      if (ph == 3) hold_request = 1'b1;
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    drain_block();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[midi_event_remapper_top.f]
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_datapath.sv
rtl/midi_event_remapper_top.sv
dv/midi_event_remapper_top_tb.sv
